// ----- design/imu_frame_sync_sliding_unit_defines.svh -----
// Assertion macros shared by the frame synchronizer modules.
// No dependencies; each module that asserts includes this header.
`ifndef IMU_FRAME_SYNC_SLIDING_UNIT_DEFINES_SVH
`define IMU_FRAME_SYNC_SLIDING_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IFSS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IFSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ifss_pkg.sv -----
// Package for the IMU frame synchronizer: frame constants, kind codes
// and the frame record passed from the front part to the back part.
// No dependencies.
`timescale 1ns / 1ps

package ifss_pkg;

    localparam int FRAME_LEN   = 11;
    localparam int SUM_LEN     = 10;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] TYPE_MASK   = 8'h50;
    localparam logic [7:0] TYPE_FIRST  = 8'h51;
    localparam logic [7:0] TYPE_LAST   = 8'h54;

    typedef enum logic [1:0] {
        KIND_ACCEL = 2'd0,
        KIND_RATE  = 2'd1,
        KIND_ANGLE = 2'd2,
        KIND_MAG   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0]  type_byte;
        logic [63:0] payload;
    } t_frame;

endpackage

// ----- design/ifss_front.sv -----
// Front part of the IMU frame synchronizer: sliding byte window, running
// checksum and frame checks. Depends on ifss_pkg and the defines header.
`timescale 1ns / 1ps
`include "imu_frame_sync_sliding_unit_defines.svh"

module ifss_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_byte,
    input  logic           i_queue_full,
    output logic           o_push,
    output ifss_pkg::t_frame o_frame
);

    logic [7:0] r_win [0:ifss_pkg::SUM_LEN-1];
    logic [3:0] r_fill;
    logic [7:0] r_sum;
    logic [3:0] n_fill;
    logic [7:0] n_sum;

    logic [3:0] slot;
    logic       accept;
    logic       done;
    logic       pass;
    logic       known_type;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        if (r_fill > 4'(ifss_pkg::SUM_LEN)) begin
            slot = 4'(ifss_pkg::SUM_LEN);
        end else begin
            slot = r_fill;
        end
        done = (slot == 4'(ifss_pkg::SUM_LEN));
        pass = (r_win[0] == ifss_pkg::HEADER_BYTE)
            && ((r_win[1] & ifss_pkg::TYPE_MASK) == ifss_pkg::TYPE_MASK)
            && (r_sum == i_byte);
        known_type = r_win[1] inside {[ifss_pkg::TYPE_FIRST:ifss_pkg::TYPE_LAST]};
    end

    always_comb begin
        n_fill = r_fill;
        n_sum  = r_sum;
        if (accept) begin
            if (!done) begin
                n_fill = slot + 4'd1;
                n_sum  = r_sum + i_byte;
            end else if (pass) begin
                n_fill = 4'd0;
                n_sum  = 8'd0;
            end else begin
                n_fill = 4'(ifss_pkg::SUM_LEN);
                n_sum  = r_sum - r_win[0] + i_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 4'd0;
            r_sum  <= 8'd0;
        end else begin
            r_fill <= n_fill;
            r_sum  <= n_sum;
        end
    end

    // The 11th byte is compared to the running sum; kept only on a mismatch.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < ifss_pkg::SUM_LEN - 1; i++) begin
                if (!done) begin
                    if (slot == 4'(i)) begin
                        r_win[i] <= i_byte;
                    end
                end else if (!pass) begin
                    r_win[i] <= r_win[i+1];
                end
            end
            if (!done) begin
                if (slot == 4'(ifss_pkg::SUM_LEN - 1)) begin
                    r_win[ifss_pkg::SUM_LEN-1] <= i_byte;
                end
            end else if (!pass) begin
                r_win[ifss_pkg::SUM_LEN-1] <= i_byte;
            end
        end
    end

    assign o_push = accept && done && pass && known_type;
    assign o_frame.type_byte = r_win[1];
    assign o_frame.payload = {r_win[9], r_win[8], r_win[7], r_win[6],
                              r_win[5], r_win[4], r_win[3], r_win[2]};

    `IFSS_ASSERT_SAME(a_fill_range, 1'b1, r_fill <= 4'(ifss_pkg::SUM_LEN),
        "window fill count out of range")
    `IFSS_ASSERT_NEXT(a_pass_empties, accept && done && pass, r_fill == 4'd0,
        "window not emptied after a valid frame")
    `IFSS_ASSERT_NEXT(a_fail_slides, accept && done && !pass,
        r_fill == 4'(ifss_pkg::SUM_LEN), "window did not slide after a failed check")

endmodule

// ----- design/ifss_queue.sv -----
// Short frame queue between the front and back parts of the synchronizer.
// Depends on ifss_pkg and the defines header.
`timescale 1ns / 1ps
`include "imu_frame_sync_sliding_unit_defines.svh"

module ifss_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ifss_pkg::t_frame i_frame,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output ifss_pkg::t_frame o_frame
);

    ifss_pkg::t_frame r_mem [0:ifss_pkg::QUEUE_DEPTH-1];
    logic [ifss_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [ifss_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [ifss_pkg::QUEUE_CW-1:0] r_count;
    logic [ifss_pkg::QUEUE_AW-1:0] n_wr_ptr;
    logic [ifss_pkg::QUEUE_AW-1:0] n_rd_ptr;
    logic [ifss_pkg::QUEUE_CW-1:0] n_count;

    assign o_full  = (r_count == ifss_pkg::QUEUE_CW'(ifss_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_frame = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            if (r_wr_ptr == ifss_pkg::QUEUE_AW'(ifss_pkg::QUEUE_DEPTH - 1)) begin
                n_wr_ptr = '0;
            end else begin
                n_wr_ptr = r_wr_ptr + 1'b1;
            end
        end
        if (i_pop) begin
            if (r_rd_ptr == ifss_pkg::QUEUE_AW'(ifss_pkg::QUEUE_DEPTH - 1)) begin
                n_rd_ptr = '0;
            end else begin
                n_rd_ptr = r_rd_ptr + 1'b1;
            end
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

    `IFSS_ASSERT_SAME(a_no_overflow, o_full, !i_push, "push into a full queue")
    `IFSS_ASSERT_SAME(a_no_underflow, o_empty, !i_pop, "pop from an empty queue")
    `IFSS_ASSERT_NEXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + 1'b1,
        "queue count did not follow a push")

endmodule

// ----- design/ifss_back.sv -----
// Back part of the synchronizer: turns a queued frame into a result and
// holds it in the output register. Depends on ifss_pkg.
`timescale 1ns / 1ps

module ifss_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  ifss_pkg::t_frame i_frame,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output ifss_pkg::t_kind  o_kind,
    output logic [63:0]      o_values
);

    logic            r_valid;
    ifss_pkg::t_kind r_kind;
    logic [63:0]     r_values;
    logic [1:0]      type_offset;

    assign o_pop       = !i_empty && (!r_valid || i_ready);
    assign type_offset = 2'(i_frame.type_byte - ifss_pkg::TYPE_FIRST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind   <= ifss_pkg::t_kind'(type_offset);
            r_values <= i_frame.payload;
        end
    end

    assign o_valid  = r_valid;
    assign o_kind   = r_kind;
    assign o_values = r_values;

endmodule

// ----- design/imu_frame_sync_sliding_unit.sv -----
// With the output free, a frame goes through the frame queue into the output register after its last byte.
// Throughput: one byte per cycle while the frame queue is not full; the window check is a running sum and compares.
// Input ready drops only when the four-entry frame queue is full behind a stalled output.
// Reset (synchronous, active low) empties the window and the queue and drops o_m_axis_tvalid.
// Top level of the IMU frame synchronizer; depends on ifss_pkg, ifss_front,
// ifss_queue and ifss_back.
`timescale 1ns / 1ps

module imu_frame_sync_sliding_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [15:0] value_x, [31:16] value_y,
                                          // [47:32] value_z, [63:48] value_extra
    output logic [1:0]  o_m_axis_tuser    // [1:0] kind
);

    logic             push;
    logic             pop;
    logic             queue_full;
    logic             queue_empty;
    ifss_pkg::t_frame front_frame;
    ifss_pkg::t_frame queue_frame;
    ifss_pkg::t_kind  kind;

    ifss_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_byte       (i_s_axis_tdata),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_frame      (front_frame)
    );

    ifss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (front_frame),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_empty (queue_empty),
        .o_frame (queue_frame)
    );

    ifss_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (queue_empty),
        .i_frame  (queue_frame),
        .o_pop    (pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_kind   (kind),
        .o_values (o_m_axis_tdata)
    );

    assign o_m_axis_tuser = kind;

endmodule
